// File: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and codes for the chunked byte ring fifo
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int LEN_W  = 13;
  localparam int DATA_W = 8;
  localparam int FILL_W = 10;
  localparam int KIND_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PUT_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUT_REJ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_DATA = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REF  = 2'd3;

  // input actions
  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_POP = 1'b1;

  typedef struct packed {
    logic              action;
    logic              first;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic [FILL_W-1:0] fill;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: design/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/byte_ring_fifo_chunked.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_chunked
// byte ring buffer with all-or-nothing put transfers and counted pops
// ----------------------------------------------------------------------------
// The buffer holds up to DEPTH-1 bytes in one ram with a registered read.
// Every put byte is one transaction in and gives one result transaction.
// The first byte of a put transfer carries its length; a transfer whose length
// is not below the free space flushes the buffer and the rest of it is dropped.
// A pop request returns its length in bytes, one result per cycle while the
// output is not stalled, oldest first, the last one marked, or a single refusal.
// For an accepted pop the first ram read goes out in the accepting cycle, then
// the input is held while one byte a cycle moves out, as long as the output
// takes them; the ram read port, one address a cycle, sets the pace.
// A stalled output holds everything back. No clearing pass is needed after
// reset: bytes are only read after being written.
`default_nettype none

module byte_ring_fifo_chunked
  import brf_pkg::*;
#(
  parameter int DEPTH   = 1024,
  parameter int MAX_POP = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;   // compare width
  localparam int PW = $clog2(MAX_POP + 1);               // pop counters

  // ring state
  state_t           state;
  logic [AW-1:0]    write_pos;
  logic [AW-1:0]    read_pos;
  logic [AW-1:0]    held;
  logic [LEN_W-1:0] put_left;
  logic             put_dropping;

  // pop sequencing
  logic [PW-1:0]    pop_left;    // bytes still to deliver
  logic [PW-1:0]    rd_left;     // ram reads still to issue

  // ram port
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [DATA_W-1:0] ram_rd_data;

  // transaction decode
  logic in_fire;
  logic out_free;
  logic is_put;
  logic is_pop;
  logic pop_ok;
  logic pop_move;
  logic pop_issue;

  // put path next values
  logic [CW-1:0]     space;
  logic [CW-1:0]     len_ext;
  logic              too_big;
  logic              try_store;
  logic              store_ok;
  logic              flush;
  logic [KIND_W-1:0] put_kind;
  logic [AW-1:0]     held_next;
  logic [AW-1:0]     write_pos_next;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign is_put   = in_fire && (in_data.action == ACT_PUT);
  assign is_pop   = in_fire && (in_data.action == ACT_POP);

  assign len_ext = CW'(in_data.length);
  assign space   = CW'(DEPTH - 1) - CW'(held);
  assign too_big = in_data.first && (len_ext >= space);

  // pop refusal: zero length, above the cap, or not strictly below the fill
  assign pop_ok = (in_data.length != '0) &&
                  (len_ext <= CW'(MAX_POP)) &&
                  (len_ext < CW'(held));

  // put decision, one byte per transaction
  always_comb begin
    try_store = 1'b0;
    flush     = 1'b0;
    put_kind  = KIND_PUT_REJ;
    if (in_data.first) begin
      if (too_big) begin
        flush = 1'b1;
      end else if (in_data.length == '0) begin
        put_kind = KIND_PUT_OK;
      end else begin
        try_store = 1'b1;
      end
    end else if (put_left != '0 && !put_dropping) begin
      try_store = 1'b1;
    end
    // full buffer turns a store into a reject
    if (try_store && (held != AW'(DEPTH - 1))) begin
      put_kind = KIND_PUT_OK;
    end
  end

  assign store_ok       = try_store && (held != AW'(DEPTH - 1));
  assign ram_wr_en      = is_put && store_ok;
  assign write_pos_next = (write_pos == AW'(DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign held_next      = flush ? '0 : (store_ok ? held + 1'b1 : held);

  // pop streaming: ram data moves into the output slot while the next read issues
  assign pop_move  = (state == ST_POP) && out_free;
  assign pop_issue = pop_move && (rd_left != '0);
  assign ram_rd_en = (is_pop && pop_ok) || pop_issue;

  brf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (write_pos),
    .wr_data (in_data.data_in),
    .rd_en   (ram_rd_en),
    .rd_addr (read_pos),
    .rd_data (ram_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_pos    <= '0;
      read_pos     <= '0;
      held         <= '0;
      put_left     <= '0;
      put_dropping <= 1'b0;
      pop_left     <= '0;
      rd_left      <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (is_put) begin
            // bookkeeping for the transfer in progress
            if (in_data.first) begin
              put_left     <= (in_data.length != '0) ? in_data.length - 1'b1 : '0;
              put_dropping <= too_big;
            end else if (put_left != '0) begin
              put_left <= put_left - 1'b1;
            end
            if (flush) begin
              write_pos <= '0;
              read_pos  <= '0;
            end else if (store_ok) begin
              write_pos <= write_pos_next;
            end
            held      <= held_next;
            out_valid <= 1'b1;
          end else if (is_pop) begin
            if (pop_ok) begin
              // first read goes out with the accepting transaction
              read_pos <= (read_pos == AW'(DEPTH - 1)) ? '0 : read_pos + 1'b1;
              pop_left <= PW'(in_data.length);
              rd_left  <= PW'(in_data.length - 1'b1);
              state    <= ST_POP;
            end
            out_valid <= !pop_ok;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        ST_POP: begin
          if (pop_move) begin
            held      <= held - 1'b1;
            pop_left  <= pop_left - 1'b1;
            out_valid <= 1'b1;
            if (pop_left == PW'(1)) begin
              state <= ST_IDLE;
            end
          end
          if (pop_issue) begin
            read_pos <= (read_pos == AW'(DEPTH - 1)) ? '0 : read_pos + 1'b1;
            rd_left  <= rd_left - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (is_put) begin
      out_data.kind     <= put_kind;
      out_data.data_out <= '0;
      out_data.last     <= 1'b1;
      out_data.fill     <= FILL_W'(held_next);
    end else if (is_pop && !pop_ok) begin
      out_data.kind     <= KIND_POP_REF;
      out_data.data_out <= '0;
      out_data.last     <= 1'b1;
      out_data.fill     <= FILL_W'(held);
    end else if (pop_move) begin
      out_data.kind     <= KIND_POP_DATA;
      out_data.data_out <= ram_rd_data;
      out_data.last     <= (pop_left == PW'(1));
      out_data.fill     <= FILL_W'(held - 1'b1);
    end
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the chunked byte ring fifo
// ----------------------------------------------------------------------------
// Put transfers and pop requests are queued up front, then driven with random
// gaps. A behavioral copy of the ring buffer predicts every result transaction
// as each request is accepted. The monitor checks results in order, field by
// field. The receiver stalls at random and twice holds off long enough to
// back the block up into its input.

module testbench;
  import brf_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int POP_MAX     = 64;
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction on either side
  localparam int DRAIN_WAIT  = 100;    // settle time once nothing is expected

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  byte_ring_fifo_chunked uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request stream and results still owed by the block
  in_t  pending_requests[$];
  out_t expected_results[$];
  int   request_total;
  int   failures = 0;

  // ---------------------------------------------------------------------------
  // ring buffer prediction
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int ring_wr, ring_rd, ring_held;
  int transfer_left;
  logic transfer_dropping;

  function automatic void owe_result(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] data,
                                     logic last);
    out_t r;
    r.kind     = kind;
    r.data_out = data;
    r.last     = last;
    r.fill     = ring_held[FILL_W-1:0];
    expected_results.push_back(r);
  endfunction

  // one slot is always kept spare, so a full ring refuses the byte
  function automatic logic [KIND_W-1:0] ring_store(logic [DATA_W-1:0] b);
    if (ring_held >= RING_DEPTH - 1) return KIND_PUT_REJ;
    ring_mem[ring_wr] = b;
    ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;
    ring_held++;
    return KIND_PUT_OK;
  endfunction

  function automatic void ring_expect(in_t req);
    int len;
    int space;
    logic [KIND_W-1:0] kind;
    len = int'(req.length);
    if (req.action == ACT_PUT) begin
      if (req.first) begin
        // the first byte decides the whole transfer; a misfit flushes the ring
        space = RING_DEPTH - 1 - ring_held;
        transfer_left = (len > 0) ? len - 1 : 0;
        if (len >= space) begin
          ring_wr = 0;
          ring_rd = 0;
          ring_held = 0;
          transfer_dropping = 1'b1;
          kind = KIND_PUT_REJ;
        end else begin
          transfer_dropping = 1'b0;
          kind = (len > 0) ? ring_store(req.data_in) : KIND_PUT_OK;
        end
      end else if (transfer_left == 0) begin
        kind = KIND_PUT_REJ;   // stray byte outside any transfer
      end else begin
        transfer_left--;
        kind = transfer_dropping ? KIND_PUT_REJ : ring_store(req.data_in);
      end
      owe_result(kind, '0, 1'b1);
    end else if (len == 0 || len > POP_MAX || len >= ring_held) begin
      owe_result(KIND_POP_REF, '0, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        logic [DATA_W-1:0] b;
        b = ring_mem[ring_rd];
        ring_rd = (ring_rd + 1 >= RING_DEPTH) ? 0 : ring_rd + 1;
        ring_held--;
        owe_result(KIND_POP_DATA, b, i + 1 == len);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building; plan_held follows the fill level so that most
  // transfers fit and most pops are served
  // ---------------------------------------------------------------------------
  int plan_held;

  function automatic void queue_request(logic act, logic fst, int len, logic [DATA_W-1:0] d);
    in_t r;
    r.action  = act;
    r.first   = fst;
    r.length  = LEN_W'(len);
    r.data_in = d;
    pending_requests.push_back(r);
  endfunction

  // a transfer announcing 'total' bytes of which 'sent' transactions go out
  function automatic void queue_transfer(int total, int sent);
    queue_request(ACT_PUT, 1'b1, total, DATA_W'($urandom));
    for (int i = 1; i < sent; i++)
      queue_request(ACT_PUT, 1'b0, $urandom_range(0, 8191), DATA_W'($urandom));
    if (total >= RING_DEPTH - 1 - plan_held) plan_held = 0;
    else if (total > 0) plan_held += sent;
  endfunction

  function automatic void queue_pop(int len);
    queue_request(ACT_POP, 1'($urandom), len, DATA_W'($urandom));
    if (len >= 1 && len <= POP_MAX && len < plan_held) plan_held -= len;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one request transaction at a time, random gap after each one
  // ---------------------------------------------------------------------------
  int   send_gap  = 0;
  logic send_fast = 1'b0;

  always @(posedge clk) begin : driver
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        offer = 1'b0;
        // runs of back-to-back requests now and then
        if ($urandom_range(0, 29) == 0) send_fast = !send_fast;
        send_gap = send_fast ? 0 : $urandom_range(0, 12);
      end else if (!in_valid && send_gap > 0) begin
        send_gap--;
      end
      if (!offer && send_gap == 0 && pending_requests.size() > 0) begin
        in_data <= pending_requests.pop_front();
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted request, then checks each result;
  // prediction sits here so a same-edge result can never race it
  // ---------------------------------------------------------------------------
  int   recv_gap   = 0;
  logic recv_fast  = 1'b0;
  int   hold_off   = 0;
  int   requests_taken = 0;
  int   results_seen   = 0;
  int   idle_cycles    = 0;

  always @(posedge clk) begin : monitor
    out_t want;
    logic took_in;
    logic took_out;
    if (rst) begin
      out_ready <= 1'b0;
      ring_wr = 0;
      ring_rd = 0;
      ring_held = 0;
      transfer_left = 0;
      transfer_dropping = 1'b0;
      recv_gap = 0;
      hold_off = 0;
      idle_cycles = 0;
    end else begin
      took_in  = in_valid && in_ready;
      took_out = out_valid && out_ready;
      if (took_in) begin
        ring_expect(in_data);
        requests_taken++;
      end
      if (took_out) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d data %0h fill %0d",
                 out_data.kind, out_data.data_out, out_data.fill);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
            failures++;
          end
          if (out_data.data_out !== want.data_out) begin
            $error("data_out: expected %0h, got %0h", want.data_out, out_data.data_out);
            failures++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            failures++;
          end
          if (out_data.fill !== want.fill) begin
            $error("fill: expected %0d, got %0d", want.fill, out_data.fill);
            failures++;
          end
        end
        results_seen++;
        // long back-pressure so the block fills up and stalls its input
        if (results_seen == 40 || results_seen == 200) hold_off = 300;
        if ($urandom_range(0, 24) == 0) recv_fast = !recv_fast;
        recv_gap = recv_fast ? 0 : $urandom_range(0, 12);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      if (hold_off > 0) hold_off--;
      idle_cycles = (took_in || took_out) ? 0 : idle_cycles + 1;
      out_ready <= (recv_gap == 0 && hold_off == 0);
    end
  end

  // watchdog on a stuck handshake
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int pick, space, len, top;
    plan_held = 0;

    // directed: empty pop, zero-length transfer, stray byte
    queue_pop(1);
    queue_transfer(0, 1);
    queue_request(ACT_PUT, 1'b0, 8191, 8'hFF);
    // normal transfer, refused pops (zero, too long, not below fill), one served pop
    queue_transfer(5, 5);
    queue_pop(0);
    queue_pop(POP_MAX + 1);
    queue_pop(5);
    queue_pop(4);
    // oversized transfer flushes, its tail is dropped
    queue_transfer(4096, 3);
    // new first byte cuts a transfer short
    queue_transfer(3, 2);
    queue_transfer(2, 2);
    queue_pop(3);
    // exact free-space edge: equal is rejected, one less is accepted
    queue_transfer(RING_DEPTH - 1 - plan_held, 1);
    queue_transfer(RING_DEPTH - 2 - plan_held, 1);
    queue_transfer(0, 1);
    queue_transfer(1, 1);
    queue_pop(1);

    while (pending_requests.size() < 280) begin
      space = RING_DEPTH - 1 - plan_held;
      pick = $urandom_range(0, 99);
      if (pick < 45 && space > 2) begin
        // well-formed transfer, mostly short
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 16);
        if (len >= space) len = space - 1;
        queue_transfer(len, len);
      end else if (pick < 72 && plan_held >= 2) begin
        // pop that is served, often the largest allowed
        top = (plan_held - 1 < POP_MAX) ? plan_held - 1 : POP_MAX;
        queue_pop(($urandom_range(0, 3) == 0) ? top : $urandom_range(1, top));
      end else if (pick < 80 && space > 3) begin
        // transfer abandoned part way by a zero-length first byte
        len = $urandom_range(2, (space - 1 < 24) ? space - 1 : 24);
        queue_transfer(len, $urandom_range(1, len - 1));
        queue_transfer(0, 1);
      end else if (pick < 86) begin
        // right at the free-space edge
        if ($urandom_range(0, 1) == 0 || space < 2) begin
          len = $urandom_range(1, 4);
          queue_transfer(space, (len < space) ? len : space);
        end else begin
          queue_transfer(space - 1, 1);
        end
        queue_transfer(0, 1);
      end else if (pick < 92) begin
        // far too long, flushes; a few dropped bytes follow
        len = $urandom_range(space, 8191);
        top = $urandom_range(1, 4);
        queue_transfer(len, (top < len) ? top : len);
        queue_transfer(0, 1);
      end else if ($urandom_range(0, 1) == 0) begin
        queue_pop($urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(60, 70));
      end else begin
        queue_request(ACT_PUT, 1'b0, $urandom_range(0, 8191), DATA_W'($urandom));
      end
    end
    request_total = pending_requests.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (requests_taken != request_total || expected_results.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
